FILE: rtl/four_vector_kinematics_assert.svh
// ----------------------------------------------------------------------------
// Four-vector kinematics assertion macros
// Shared property forms for the pipeline checks.
// ----------------------------------------------------------------------------
`ifndef FOUR_VECTOR_KINEMATICS_ASSERT_SVH
`define FOUR_VECTOR_KINEMATICS_ASSERT_SVH

// implication checked every edge outside reset
`define FVK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FVK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/fvk_pkg.sv
// ----------------------------------------------------------------------------
// Four-vector kinematics package
// Arctangent table in units of 2^-32 turn and fixed angle constants.
// ----------------------------------------------------------------------------
`default_nettype none
package fvk_pkg;
  localparam int TAB_LEN = 24;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] THREEQ_TURN  = 32'hC000_0000;
  localparam int PRESCALE_SHIFT = 16;

  function automatic logic [31:0] atan_tab(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/fvk_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, restoring method, rounded down. Carries a tag.
// ----------------------------------------------------------------------------
`default_nettype none
module fvk_sqrt_pipe #(
  parameter int IN_W  = 36,
  parameter int TAG_W = 1
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [IN_W-1:0]    rad,
  input  wire logic [TAG_W-1:0]   tag_in,
  output logic [(IN_W+1)/2-1:0]   root,
  output logic [TAG_W-1:0]        tag_out
);
  localparam int RW = (IN_W + 1) / 2;
  localparam int NW = 2 * RW;

  logic [NW-1:0]    rem_r  [RW+1];
  logic [RW-1:0]    res_r  [RW+1];
  logic [TAG_W-1:0] tag_r  [RW+1];

  always_comb begin
    rem_r[0] = NW'(rad);
    res_r[0] = '0;
    tag_r[0] = tag_in;
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int SH = 2 * (RW - 1 - s);
    logic [NW+1:0] trial;
    logic [NW-1:0] rem_nxt;
    logic [RW-1:0] res_nxt;
    logic [NW-1:0] rem_q;
    logic [RW-1:0] res_q;
    logic [TAG_W-1:0] tag_q;
    always_comb begin
      trial = (NW+2)'(rem_r[s] >> SH) - (NW+2)'({res_r[s], 2'b01});
      if (!trial[NW+1]) begin
        rem_nxt = rem_r[s] - (NW'({res_r[s], 2'b01}) << SH);
        res_nxt = {res_r[s][RW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_r[s];
        res_nxt = {res_r[s][RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_nxt;
        res_q <= res_nxt;
        tag_q <= tag_r[s];
      end
    end
    always_comb begin
      rem_r[s+1] = rem_q;
      res_r[s+1] = res_q;
      tag_r[s+1] = tag_q;
    end
  end

  assign root    = res_r[RW];
  assign tag_out = tag_r[RW];
endmodule
`default_nettype wire

FILE: rtl/fvk_cordic_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// atan2(y, x) in 2^-32 turn, axis cases bypassed, one iteration per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module fvk_cordic_pipe
  import fvk_pkg::*;
#(
  parameter int IN_W  = 19,
  parameter int STEPS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [IN_W-1:0] x_in,
  input  wire logic signed [IN_W-1:0] y_in,
  output logic [31:0]                 angle
);
  localparam int NS = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
  localparam int W  = IN_W + PRESCALE_SHIFT + 3;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic [31:0]         z;
    logic                fix;
  } cstate_t;

  cstate_t st [NS+1];
  cstate_t st0_r;
  cstate_t pre;

  always_comb begin
    pre = '0;
    if (x_in == '0 && y_in == '0) begin
      pre.fix = 1'b1;
    end else if (y_in == '0) begin
      pre.fix = 1'b1;
      pre.z   = (x_in > 0) ? '0 : HALF_TURN;
    end else if (x_in == '0) begin
      pre.fix = 1'b1;
      pre.z   = (y_in > 0) ? QUARTER_TURN : THREEQ_TURN;
    end else if (x_in < 0) begin
      pre.x = -(W'(x_in) <<< PRESCALE_SHIFT);
      pre.y = -(W'(y_in) <<< PRESCALE_SHIFT);
      pre.z = HALF_TURN;
    end else begin
      pre.x = W'(x_in) <<< PRESCALE_SHIFT;
      pre.y = W'(y_in) <<< PRESCALE_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st0_r <= pre;
  end
  assign st[0] = st0_r;

  for (genvar i = 0; i < NS; i++) begin : g_iter
    cstate_t nxt, q;
    always_comb begin
      nxt = st[i];
      if (!st[i].fix) begin
        if (st[i].y > 0) begin
          nxt.x = st[i].x + (st[i].y >>> i);
          nxt.y = st[i].y - (st[i].x >>> i);
          nxt.z = st[i].z + atan_tab(i);
        end else begin
          nxt.x = st[i].x - (st[i].y >>> i);
          nxt.y = st[i].y + (st[i].x >>> i);
          nxt.z = st[i].z - atan_tab(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) q <= nxt;
    end
    assign st[i+1] = q;
  end

  assign angle = st[NS].z;
endmodule
`default_nettype wire

FILE: rtl/four_vector_kinematics.sv
// An input beat passes the magnitude, square, square-root, CORDIC and clamp-and-round stages in order.
// Throughput: one beat per cycle while the output is not stalled; square-root and
// CORDIC pipelines advance together, one bit or one iteration per stage.
// The output stall freezes every stage at once; a valid bit rides each stage.
// Reset (rst_n low, synchronous) clears the valid bits only.
// ----------------------------------------------------------------------------
// Four-vector kinematics
// pt, invariant mass, theta and phi from a four-momentum, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_vector_kinematics_assert.svh"
module four_vector_kinematics
  import fvk_pkg::*;
#(
  parameter int MOM_WIDTH    = 18,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [MOM_WIDTH-1:0] in_mom_x,
  input  wire logic signed [MOM_WIDTH-1:0] in_mom_y,
  input  wire logic signed [MOM_WIDTH-1:0] in_mom_z,
  input  wire logic signed [MOM_WIDTH-1:0] in_energy,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [MOM_WIDTH-1:0]             out_transverse_mom,
  output logic [MOM_WIDTH-1:0]             out_inv_mass,
  output logic [ANGLE_WIDTH-1:0]           out_polar_angle,
  output logic [ANGLE_WIDTH-1:0]           out_azimuth,
  output logic                             out_mass_invalid
);
  localparam int SQW  = 2 * MOM_WIDTH + 2;
  localparam int RW   = (SQW + 1) / 2;
  localparam int NS   = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int PHW  = NS + 1;
  localparam int LAT  = 2 + RW + 1 + NS + 1;
  localparam int CW   = RW + 1;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
  end
  assign out_valid = vld_r[LAT-1];

  // stage 1: magnitudes
  logic [MOM_WIDTH-1:0] ax_r, ay_r, az_r, ae_r;
  logic signed [MOM_WIDTH-1:0] pz0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= in_mom_x[MOM_WIDTH-1] ? MOM_WIDTH'(-in_mom_x) : in_mom_x;
      ay_r  <= in_mom_y[MOM_WIDTH-1] ? MOM_WIDTH'(-in_mom_y) : in_mom_y;
      az_r  <= in_mom_z[MOM_WIDTH-1] ? MOM_WIDTH'(-in_mom_z) : in_mom_z;
      ae_r  <= in_energy[MOM_WIDTH-1] ? MOM_WIDTH'(-in_energy) : in_energy;
      pz0_r <= in_mom_z;
    end
  end

  // stage 2: squares
  logic [SQW-1:0] pt2_r, m2_r;
  logic           bad_r;
  logic signed [MOM_WIDTH-1:0] pz1_r;
  logic [2*MOM_WIDTH-1:0] sx, sy, sz, se;
  logic [SQW-1:0] p2;
  always_comb begin
    sx = ax_r * ax_r;
    sy = ay_r * ay_r;
    sz = az_r * az_r;
    se = ae_r * ae_r;
    p2 = SQW'(sx) + SQW'(sy) + SQW'(sz);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pt2_r <= SQW'(sx) + SQW'(sy);
      bad_r <= SQW'(se) < p2;
      m2_r  <= (SQW'(se) < p2) ? '0 : SQW'(se) - p2;
      pz1_r <= pz0_r;
    end
  end

  logic [RW-1:0] pt_root, m_root;
  logic [MOM_WIDTH-1:0] pt_tag;
  logic           bad_tag;

  fvk_sqrt_pipe #(.IN_W(SQW), .TAG_W(MOM_WIDTH)) u_sqrt_pt (
    .clk(clk), .en(en), .rad(pt2_r), .tag_in(pz1_r),
    .root(pt_root), .tag_out(pt_tag)
  );
  fvk_sqrt_pipe #(.IN_W(SQW), .TAG_W(1)) u_sqrt_m (
    .clk(clk), .en(en), .rad(m2_r), .tag_in(bad_r),
    .root(m_root), .tag_out(bad_tag)
  );

  logic signed [CW-1:0] th_x, th_y;
  assign th_x = CW'(signed'(pt_tag));
  assign th_y = signed'({1'b0, pt_root});

  logic [31:0] th_ang, ph_ang;
  fvk_cordic_pipe #(.IN_W(CW), .STEPS(CORDIC_STEPS)) u_cordic_th (
    .clk(clk), .en(en), .x_in(th_x), .y_in(th_y), .angle(th_ang)
  );

  // phi inputs delayed to line up with theta
  logic signed [MOM_WIDTH-1:0] px_d [RW+2];
  logic signed [MOM_WIDTH-1:0] py_d [RW+2];
  always_ff @(posedge clk) begin
    if (en) begin
      px_d[0] <= in_mom_x;
      py_d[0] <= in_mom_y;
      for (int k = 1; k < RW + 2; k++) begin
        px_d[k] <= px_d[k-1];
        py_d[k] <= py_d[k-1];
      end
    end
  end
  fvk_cordic_pipe #(.IN_W(MOM_WIDTH), .STEPS(CORDIC_STEPS)) u_cordic_ph (
    .clk(clk), .en(en), .x_in(px_d[RW+1]), .y_in(py_d[RW+1]), .angle(ph_ang)
  );

  // root values delayed through the CORDIC depth
  logic [MOM_WIDTH-1:0] pt_d  [PHW];
  logic [MOM_WIDTH-1:0] m_d   [PHW];
  logic                 bad_d [PHW];
  always_ff @(posedge clk) begin
    if (en) begin
      pt_d[0]  <= MOM_WIDTH'(pt_root);
      m_d[0]   <= MOM_WIDTH'(m_root);
      bad_d[0] <= bad_tag;
      for (int k = 1; k < PHW; k++) begin
        pt_d[k]  <= pt_d[k-1];
        m_d[k]   <= m_d[k-1];
        bad_d[k] <= bad_d[k-1];
      end
    end
  end

  // final stage: clamp and round
  logic [31:0] th_c, th_rnd, ph_rnd;
  always_comb begin
    if (th_ang > THREEQ_TURN) th_c = '0;
    else if (th_ang > HALF_TURN) th_c = HALF_TURN;
    else th_c = th_ang;
    th_rnd = th_c + (32'd1 << (31 - ANGLE_WIDTH));
    ph_rnd = ph_ang + (32'd1 << (31 - ANGLE_WIDTH));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_transverse_mom <= pt_d[PHW-1];
      out_inv_mass       <= m_d[PHW-1];
      out_mass_invalid   <= bad_d[PHW-1];
      out_polar_angle    <= th_rnd[31 -: ANGLE_WIDTH];
      out_azimuth        <= ph_rnd[31 -: ANGLE_WIDTH];
    end
  end

  `FVK_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid)
  `FVK_ASSERT_IMPL(a_mass_zero, out_valid && out_mass_invalid, out_inv_mass == '0)
  `FVK_ASSERT_IMPL(a_theta_range, out_valid,
                   out_polar_angle <= (ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1)))
  `FVK_ASSERT_IMPL(a_stall_in, out_valid && out_stall, in_stall)
endmodule
`default_nettype wire
